// File: src/pbrr_pkg.sv
`timescale 1ns / 1ps

package pbrr_pkg;

    localparam int OFF_W = 24;
    localparam int LEN_W = 17;

    localparam logic [31:0] CMD_HEAD_WORD  = 32'h02AA_0000;
    localparam logic [31:0] CMD_WEAVE_WORD = 32'h03AA_0000;
    localparam logic [31:0] CMD_BACK_WORD  = 32'h0D0A_0000;
    localparam logic [7:0]  DATA_REQ_TOP   = 8'h0A;
    localparam logic [7:0]  READY_BYTE     = 8'hAA;
    localparam logic [7:0]  END_BYTE       = 8'hFF;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_HEAD  = 2'd1;
    localparam logic [1:0] MODE_WEAVE = 2'd2;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ECHO = 2'd3;

    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] command_word;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic [1:0] reply_kind;
        logic [1:0] mode_after;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic cfg_we;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reply_pending;
    } dp_status_t;

endpackage

// File: src/pbrr_ctrl.sv
`timescale 1ns / 1ps

module pbrr_ctrl
    import pbrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       cfg_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       cfg_ready,
    output logic       rsp_valid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_REPLY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.reply_pending ? ST_REPLY : ST_IDLE;
            end
            ST_REPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = (state_reg == ST_REPLY);
    assign cmd.capture = start && (state_reg == ST_IDLE);
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.cfg_we  = cfg_valid && cfg_ready;

    // a reply cycle always follows an execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLY) |-> $past(state_reg == ST_EXEC))
        else $error("reply without execute");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("captured item not executed");

endmodule

// File: src/pbrr_dp.sv
`timescale 1ns / 1ps

module pbrr_dp
    import pbrr_pkg::*;
#(
    parameter int PATTERN_DEPTH = 65536
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  ctrl_cmd_t       cmd,
    input  req_t            req,
    input  logic [LEN_W-1:0] cfg_data,
    output dp_status_t      status,
    output rsp_t            rsp
);

    localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam logic [OFF_W:0] DEPTH_W = (OFF_W + 1)'(PATTERN_DEPTH);

    logic [7:0] mem [PATTERN_DEPTH];

    req_t             item_reg;
    logic [LEN_W-1:0] length_reg;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic [1:0]       kind_reg;
    logic [1:0]       kind_next;
    logic [7:0]       rd_data_reg;
    logic             has_reply;

    logic [OFF_W-1:0] wr_addr;
    logic [OFF_W-1:0] rd_addr;
    logic             wr_en;
    logic             rd_en;
    logic             is_cmd;

    assign wr_addr = {8'd0, item_reg.load_address};
    assign rd_addr = item_reg.command_word[OFF_W-1:0];
    assign is_cmd  = (item_reg.req_type == REQ_CMD) && (item_reg.command_word != 32'd0);
    assign wr_en   = (item_reg.req_type == REQ_LOAD) && ({1'b0, wr_addr} < DEPTH_W);
    assign rd_en   = ({1'b0, rd_addr} < {8'd0, length_reg})
                     && ({1'b0, rd_addr} < DEPTH_W);

    always_comb
    begin
        mode_next = mode_reg;
        byte_next = item_reg.command_word[31:24];
        kind_next = KIND_ECHO;
        has_reply = 1'b0;
        if (is_cmd)
        begin
            if (mode_reg == MODE_IDLE)
            begin
                if (item_reg.command_word == CMD_HEAD_WORD)
                begin
                    mode_next = MODE_HEAD;
                    byte_next = READY_BYTE;
                    kind_next = KIND_ACK;
                    has_reply = 1'b1;
                end
                else if (item_reg.command_word == CMD_WEAVE_WORD)
                begin
                    mode_next = MODE_WEAVE;
                    byte_next = READY_BYTE;
                    kind_next = KIND_ACK;
                    has_reply = 1'b1;
                end
            end
            else if (item_reg.command_word[31:24] == DATA_REQ_TOP)
            begin
                kind_next = rd_en ? KIND_DATA : KIND_END;
                byte_next = END_BYTE;
                has_reply = 1'b1;
            end
            else if (item_reg.command_word == CMD_BACK_WORD)
            begin
                mode_next = MODE_IDLE;
            end
            else
            begin
                has_reply = 1'b1;
            end
        end
    end

    assign status.reply_pending = has_reply;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            length_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                mode_reg <= mode_next;
            end
            if (cmd.cfg_we)
            begin
                length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.exec)
        begin
            byte_reg <= byte_next;
            kind_reg <= kind_next;
        end
    end

    // pattern store: one write or one read per execute cycle
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr[ADDR_W-1:0]] <= item_reg.load_byte;
        end
        if (cmd.exec && is_cmd && rd_en)
        begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    assign rsp.reply_byte = (kind_reg == KIND_DATA) ? rd_data_reg : byte_reg;
    assign rsp.reply_kind = kind_reg;
    assign rsp.mode_after = mode_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && wr_en) |-> !has_reply)
        else $error("load item produced a reply");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && has_reply && (kind_next == KIND_ACK)) |=> (mode_reg != MODE_IDLE))
        else $error("ack without entering a transfer mode");

endmodule

// File: src/pattern_byte_request_responder.sv
`timescale 1ns / 1ps

// Pattern byte request responder.
// Request channel: an item (req) is taken at a clock edge with start high and
// busy low. req_type selects a machine command word or a pattern byte load.
// Reply channel: rsp is valid for exactly one cycle while rsp_valid is high;
// the receiver cannot stall it, so it must take the item in that cycle.
// Config channel: cfg_data (pattern length) is written on cfg_valid && cfg_ready;
// cfg_ready is high only while the block is idle.
// Sequence: the accept edge moves to the execute state (decode plus one pattern
// store port access), then to the reply state when the item has a reply; busy
// is high in the execute and reply states. The pattern store read is registered
// before the reply.
// Reset clears the transfer mode to idle and the pattern length to zero; the
// pattern store is not cleared and reads of unwritten bytes are undefined.
module pattern_byte_request_responder
    import pbrr_pkg::*;
#(
    parameter int PATTERN_DEPTH = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             rsp_valid,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing: idle / execute / reply
    pbrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .rsp_valid (rsp_valid)
    );

    // item register, mode, length register, pattern store, reply regs
    pbrr_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .status   (status),
        .rsp      (rsp)
    );

    // a reply is only shown inside an item's busy window
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> busy)
        else $error("reply outside busy window");

    // an accepted item holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // a reply ends the item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |=> !busy && !rsp_valid)
        else $error("reply not single cycle");

    // ready ack always leaves the block in a transfer mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.reply_kind == KIND_ACK)) |-> (rsp.mode_after != MODE_IDLE))
        else $error("ack reply with idle mode");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// Bench for the pattern byte request responder.
// One process drives items and keeps a software copy of the responder
// (mode, pattern length, pattern bytes). A second process takes each reply
// strobe and compares it with the oldest predicted reply.
module tb;
    import pbrr_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int ITEM_TARGET = 1000;
    localparam int PHASES      = 5;
    localparam int SHOW_MAX    = 10;
    localparam int SETTLE_CYC  = 4;

    // How a directed row is checked: against the predictor, against a reply
    // typed into the table, or as an item that must stay silent.
    typedef enum {CHK_MODEL, CHK_REPLY, CHK_SILENT} chk_t;

    typedef struct {
        bit               is_cfg;
        logic [LEN_W-1:0] len;
        req_t             item;
        chk_t             chk;
        rsp_t             want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             rsp_valid;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    // Predicted responder state.
    logic [1:0]       pat_mode;
    logic [LEN_W-1:0] pat_len;
    logic [7:0]       pat_store [STORE_DEPTH];
    bit               pat_written [STORE_DEPTH];
    logic [15:0]      loaded_addrs [$];

    rsp_t             pending_replies [$];
    dir_row_t         dir_rows [$];

    int err_cnt      = 0;
    int items_sent   = 0;
    int replies_seen = 0;
    int cfg_writes   = 0;
    int kind_seen [4];

    pattern_byte_request_responder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: what the responder answers to one accepted item.
    // moved is low only for items the block ignores outright.
    // ------------------------------------------------------------------
    task automatic predict_reply(input req_t it, output bit has, output rsp_t r,
                                 output bit moved);
        logic [7:0]  top;
        logic [23:0] off;
        top   = it.command_word[31:24];
        off   = it.command_word[OFF_W-1:0];
        has   = 1'b0;
        r     = '0;
        moved = 1'b1;
        if (it.req_type == REQ_LOAD)
        begin
            // loads land whatever the mode, silently
            pat_store[it.load_address]   = it.load_byte;
            pat_written[it.load_address] = 1'b1;
            loaded_addrs.push_back(it.load_address);
            return;
        end
        if (it.command_word == '0)
        begin
            moved = 1'b0;
            return;
        end
        if (pat_mode == MODE_IDLE)
        begin
            if (it.command_word == CMD_HEAD_WORD)
                pat_mode = MODE_HEAD;
            else if (it.command_word == CMD_WEAVE_WORD)
                pat_mode = MODE_WEAVE;
            else
            begin
                moved = 1'b0;
                return;
            end
            has = 1'b1;
            r   = {READY_BYTE, KIND_ACK, pat_mode};
            return;
        end
        if (top == DATA_REQ_TOP)
        begin
            // pat_len never exceeds the store, so off < pat_len stays inside it
            has = 1'b1;
            if (off < pat_len)
                r = {pat_store[off[15:0]], KIND_DATA, pat_mode};
            else
                r = {END_BYTE, KIND_END, pat_mode};
            return;
        end
        if (it.command_word == CMD_BACK_WORD)
        begin
            pat_mode = MODE_IDLE;
            return;
        end
        // head/weave inside a transfer falls here too
        has = 1'b1;
        r   = {top, KIND_ECHO, pat_mode};
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offset for a data request. Never lands on an unwritten byte below the
    // pattern length; anything at or past the length is fair game.
    function automatic logic [23:0] pick_offset();
        logic [23:0] off;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 6 && loaded_addrs.size() > 0)
            off = {8'd0, loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]};
        else if (r == 6 && pat_len != 0)
            off = {7'd0, pat_len - 17'd1};
        else if (r < 8)
            off = {7'd0, pat_len} + 24'($urandom_range(0, 3));
        else if (r == 8)
            off = 24'($urandom);
        else
            off = 24'hFF_FFFF;
        if (off < pat_len && !pat_written[off[15:0]])
            off = {7'd0, pat_len};
        return off;
    endfunction

    // Mostly well-formed sessions (enter mode, read bytes, leave), with loads,
    // zero words and random words mixed in. Unused fields carry random noise.
    function automatic req_t gen_random_item();
        req_t it;
        int   r;
        int   r2;
        it.req_type     = REQ_CMD;
        it.command_word = $urandom;
        it.load_address = 16'($urandom);
        it.load_byte    = 8'($urandom);
        r               = $urandom_range(0, 99);
        r2              = $urandom_range(0, 99);
        if (r < 18)
        begin
            it.req_type = REQ_LOAD;
            if (r2 < 60)
                it.load_address = 16'($urandom_range(0, 511));
            else if (r2 >= 90)
                it.load_address = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else if (r < 22)
            it.command_word = '0;
        else if (r < 28)
            ;   // random word as is
        else if (pat_mode == MODE_IDLE)
            it.command_word = $urandom_range(0, 1) ? CMD_HEAD_WORD : CMD_WEAVE_WORD;
        else if (r2 < 70)
            it.command_word[31:24] = DATA_REQ_TOP;
        else if (r2 < 82)
            it.command_word = CMD_BACK_WORD;
        else if (r2 < 88)
            it.command_word = $urandom_range(0, 1) ? CMD_HEAD_WORD : CMD_WEAVE_WORD;
        if (it.req_type == REQ_CMD && it.command_word[31:24] == DATA_REQ_TOP)
            it.command_word[23:0] = pick_offset();
        return it;
    endfunction

    function automatic void dir_cfg(input logic [LEN_W-1:0] len);
        dir_row_t row;
        row        = '{is_cfg: 1'b0, len: '0, item: '0, chk: CHK_SILENT, want: '0};
        row.is_cfg = 1'b1;
        row.len    = len;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_load(input logic [15:0] addr, input logic [7:0] data,
                                     input bit noise);
        dir_row_t row;
        row                   = '{is_cfg: 1'b0, len: '0, item: '0, chk: CHK_SILENT,
                                  want: '0};
        row.item.req_type     = REQ_LOAD;
        row.item.load_address = addr;
        row.item.load_byte    = data;
        row.item.command_word = noise ? 32'hFFFF_FFFF : 32'h0;
        row.chk               = CHK_SILENT;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_cmd(input logic [31:0] word, input chk_t chk,
                                    input logic [7:0] rbyte, input logic [1:0] kind,
                                    input logic [1:0] mode, input bit noise);
        dir_row_t row;
        row                   = '{is_cfg: 1'b0, len: '0, item: '0, chk: CHK_SILENT,
                                  want: '0};
        row.item.req_type     = REQ_CMD;
        row.item.command_word = word;
        row.item.load_address = noise ? 16'hFFFF : 16'h0;
        row.item.load_byte    = noise ? 8'hFF : 8'h0;
        row.chk               = chk;
        row.want              = {rbyte, kind, mode};
        dir_rows.push_back(row);
    endfunction

    // Present one item, optionally after a gap, and hold it until taken.
    // start stays high between back-to-back items.
    task automatic drive_item(input req_t it, input int idle_pct, output bit has,
                              output rsp_t r, output bit moved);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= it;
        do @(posedge clk); while (busy);
        items_sent++;
        predict_reply(it, has, r, moved);
    endtask

    // Quiet the request side and let the block finish everything in flight.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_pattern_length(input logic [LEN_W-1:0] len);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        pat_len = len;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Reply checker: every strobe must match the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid)
        begin
            replies_seen++;
            kind_seen[rsp.reply_kind]++;
            if (pending_replies.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= SHOW_MAX)
                    $display("%0t unexpected reply: byte=%h kind=%0d mode=%0d",
                             $realtime, rsp.reply_byte, rsp.reply_kind, rsp.mode_after);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.reply_byte !== want.reply_byte || rsp.reply_kind !== want.reply_kind
                    || rsp.mode_after !== want.mode_after)
                begin
                    err_cnt++;
                    if (err_cnt <= SHOW_MAX)
                        $display({"%0t reply mismatch: byte exp %h got %h, ",
                                  "kind exp %0d got %0d, mode exp %0d got %0d"},
                                 $realtime, want.reply_byte, rsp.reply_byte,
                                 want.reply_kind, rsp.reply_kind,
                                 want.mode_after, rsp.mode_after);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit               has;
        bit               moved;
        rsp_t             r;
        int               done_items;
        int               guard;
        int               idle_pct [PHASES];
        logic [LEN_W-1:0] phase_len [PHASES];

        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        pat_mode  = MODE_IDLE;
        pat_len   = '0;

        // Directed table. Pattern length is zero out of reset.
        dir_load(16'h0000, 8'h5A, 1'b0);
        dir_load(16'hFFFF, 8'hFF, 1'b1);
        dir_load(16'h0001, 8'h00, 1'b0);
        // idle ignores everything but head and weave
        dir_cmd({DATA_REQ_TOP, 24'h0}, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd(32'h0, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd(CMD_BACK_WORD, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd(CMD_HEAD_WORD, CHK_REPLY, READY_BYTE, KIND_ACK, MODE_HEAD, 1'b1);
        // length still zero: any offset is end of data
        dir_cmd({DATA_REQ_TOP, 24'h0}, CHK_REPLY, END_BYTE, KIND_END, MODE_HEAD, 1'b0);
        dir_cmd(32'h0, CHK_SILENT, 8'h00, KIND_ACK, MODE_HEAD, 1'b0);
        // head inside a transfer is just a bad command
        dir_cmd(CMD_HEAD_WORD, CHK_REPLY, 8'h02, KIND_ECHO, MODE_HEAD, 1'b0);
        dir_cmd(32'hFFFF_FFFF, CHK_REPLY, 8'hFF, KIND_ECHO, MODE_HEAD, 1'b1);
        dir_cmd(CMD_BACK_WORD, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cfg(17'h1_0000);
        dir_cmd(CMD_WEAVE_WORD, CHK_REPLY, READY_BYTE, KIND_ACK, MODE_WEAVE, 1'b0);
        dir_cmd({DATA_REQ_TOP, 24'h00_0000}, CHK_MODEL, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd({DATA_REQ_TOP, 24'h00_FFFF}, CHK_MODEL, 8'h00, KIND_ACK, MODE_IDLE, 1'b1);
        // offsets past the store read as end of data
        dir_cmd({DATA_REQ_TOP, 24'h01_0000}, CHK_REPLY, END_BYTE, KIND_END, MODE_WEAVE, 1'b0);
        dir_cmd({DATA_REQ_TOP, 24'hFF_FFFF}, CHK_REPLY, END_BYTE, KIND_END, MODE_WEAVE, 1'b0);
        dir_cmd({DATA_REQ_TOP, 24'h00_0001}, CHK_MODEL, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd(CMD_WEAVE_WORD, CHK_REPLY, 8'h03, KIND_ECHO, MODE_WEAVE, 1'b0);
        // near misses of the back word and a zero top byte both echo
        dir_cmd(32'h0D0A_0001, CHK_REPLY, 8'h0D, KIND_ECHO, MODE_WEAVE, 1'b0);
        dir_cmd(32'h0000_0001, CHK_REPLY, 8'h00, KIND_ECHO, MODE_WEAVE, 1'b0);
        dir_cfg(17'd1);
        dir_cmd({DATA_REQ_TOP, 24'h00_0001}, CHK_REPLY, END_BYTE, KIND_END, MODE_WEAVE, 1'b0);
        dir_cmd({DATA_REQ_TOP, 24'h00_0000}, CHK_MODEL, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        // load in the middle of a transfer
        dir_load(16'h0002, 8'hA5, 1'b1);
        dir_cmd(CMD_BACK_WORD, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);
        dir_cmd(CMD_HEAD_WORD, CHK_REPLY, READY_BYTE, KIND_ACK, MODE_HEAD, 1'b0);
        dir_cmd(CMD_BACK_WORD, CHK_SILENT, 8'h00, KIND_ACK, MODE_IDLE, 1'b0);

        // Random phases: pattern length per phase, sender gap rate per phase.
        phase_len[0] = 17'h1_0000;  idle_pct[0] = 15;
        phase_len[1] = 17'($urandom_range(2, 4096));  idle_pct[1] = 15;
        phase_len[2] = '0;          idle_pct[2] = 84;
        phase_len[3] = 17'd300;     idle_pct[3] = 84;
        phase_len[4] = 17'd1;       idle_pct[4] = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                set_pattern_length(dir_rows[i].len);
            else
            begin
                drive_item(dir_rows[i].item, 0, has, r, moved);
                if (dir_rows[i].chk == CHK_REPLY)
                    pending_replies.push_back(dir_rows[i].want);
                else if (dir_rows[i].chk == CHK_MODEL && has)
                    pending_replies.push_back(r);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_pattern_length(phase_len[ph]);
            done_items = 0;
            while (done_items < ITEM_TARGET / PHASES)
            begin
                drive_item(gen_random_item(), idle_pct[ph], has, r, moved);
                if (has)
                    pending_replies.push_back(r);
                if (moved)
                    done_items++;
            end
        end

        // Drain, with a bound, then wait on for stray strobes.
        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (pending_replies.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            err_cnt += pending_replies.size();
            $display("%0d predicted replies never came out", pending_replies.size());
        end

        $display("Sent %0d items over %0d length settings, checked %0d replies",
                 items_sent, cfg_writes, replies_seen);
        $display("Replies by kind: ack %0d, data %0d, end %0d, echo %0d; errors %0d",
                 kind_seen[KIND_ACK], kind_seen[KIND_DATA], kind_seen[KIND_END],
                 kind_seen[KIND_ECHO], err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
